// File: rtl/core/cmwc_pkg.sv
package cmwc_pkg;

    localparam int WORD_W  = 32;
    localparam int CARRY_W = 15;
    localparam int PROD_W  = WORD_W + CARRY_W;

    localparam logic [CARRY_W-1:0] MUL_A      = 15'd18782;
    localparam logic [WORD_W-1:0]  COMP_R     = 32'hFFFF_FFFE;
    localparam logic [CARRY_W-1:0] SEED_CARRY = 15'd18781;
    localparam logic [WORD_W-1:0]  PHI_RESET  = 32'h9E37_79B9;

    typedef enum logic {
        OP_DRAW = 1'b0,
        OP_SEED = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_RD,
        ST_MUL,
        ST_ADD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [WORD_W-1:0]  entry;
        logic [CARRY_W-1:0] carry;
    } mwc_result_t;

endpackage

// File: rtl/core/cmwc_ram.sv
module cmwc_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [cmwc_pkg::WORD_W-1:0] wdata,
    input  logic [AW-1:0]              raddr,
    output logic [cmwc_pkg::WORD_W-1:0] rdata
);
    import cmwc_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/cmwc_mwc.sv
module cmwc_mwc (
    input  logic                         aclk,
    input  logic                         load,
    input  logic [cmwc_pkg::WORD_W-1:0]  q,
    input  logic [cmwc_pkg::CARRY_W-1:0] carry,
    output cmwc_pkg::mwc_result_t        res
);
    import cmwc_pkg::*;

    logic [PROD_W-1:0]  t_reg;
    logic [PROD_W-1:0]  t_next;
    logic [CARRY_W-1:0] c_hi;
    logic [WORD_W:0]    sum;
    logic               wrap;
    logic [WORD_W-1:0]  x;

    // multiply stage: t = a*q + carry
    assign t_next = PROD_W'(MUL_A) * PROD_W'(q) + PROD_W'(carry);

    always_ff @(posedge aclk) begin
        if (load) begin
            t_reg <= t_next;
        end
    end

    // fold the high word back in; bump both on wrap
    assign c_hi = t_reg[PROD_W-1:WORD_W];
    assign sum  = {1'b0, t_reg[WORD_W-1:0]} + (WORD_W+1)'(c_hi);
    assign wrap = sum[WORD_W];
    assign x    = sum[WORD_W-1:0] + WORD_W'(wrap);

    assign res.entry = COMP_R - x;
    assign res.carry = c_hi + CARRY_W'(wrap);

endmodule

// File: rtl/core/cmwc_lag_table_random_generator.sv
// CMWC4096 random number generator with a 4096-word lag table in block RAM.
//
// Input channel (s_valid/s_ready): s_op selects a draw or a seed; s_seed_value
// is used only by a seed item. Result channel (m_valid/m_ready): one item per
// input item, m_random_value holding the drawn word, or zero with m_seed_done
// set to acknowledge a seed. cfg_wr_en/cfg_wr_data write the phi mixing
// constant; write it only while the block is idle.
//
// Timing: s_ready is high only in the idle state. A draw passes through RAM
// read, multiply, carry fold and write back, and result load, after which the
// block returns to idle and takes the next item; one item is in progress at a
// time, set by the single RAM port pair and the shared multiply-with-carry unit.
// A seed fills the table at one word a cycle, then runs 4096 discarded draws
// before its acknowledgement is loaded.
//
// A finished result sits in a holding register until the output register is
// free, so a stalled receiver holds m_valid and the payload steady while the
// block is already idle and ready for the next item. Reset (synchronous,
// active low) clears carry to 18781, index to 4095 and phi to its default;
// the table contents stay undefined, so seed before the first draw.
module cmwc_lag_table_random_generator #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic [cmwc_pkg::WORD_W-1:0]  s_seed_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [cmwc_pkg::WORD_W-1:0]  m_random_value,
    output logic                         m_seed_done,
    input  logic                         cfg_wr_en,
    input  logic [cmwc_pkg::WORD_W-1:0]  cfg_wr_data
);
    import cmwc_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

    state_t             state_reg, state_next;
    logic [AW-1:0]      cnt_reg, cnt_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [CARRY_W-1:0] carry_reg, carry_next;
    logic               seeding_reg, seeding_next;
    logic [WORD_W-1:0]  phi_reg;
    // last three words written during the fill
    logic [WORD_W-1:0]  h1_reg, h1_next;
    logic [WORD_W-1:0]  h2_reg, h2_next;
    logic [WORD_W-1:0]  h3_reg, h3_next;
    logic [WORD_W-1:0]  res_value_reg, res_value_next;
    logic               res_done_reg, res_done_next;
    logic               m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]  m_value_reg, m_value_next;
    logic               m_done_reg, m_done_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;
    logic [WORD_W-1:0]  fill_val;
    mwc_result_t        mwc_res;

    cmwc_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cmwc_mwc u_mwc (
        .aclk  (aclk),
        .load  (state_reg == ST_MUL),
        .q     (ram_rdata),
        .carry (carry_reg),
        .res   (mwc_res)
    );

    // Fill word: seed, then seed plus phi, then seed plus twice phi, then the xor recurrence.
    always_comb begin
        priority if (cnt_reg == '0) begin
            fill_val = h1_reg;
        end else if (cnt_reg < AW'(3)) begin
            fill_val = h1_reg + phi_reg;
        end else begin
            fill_val = h3_reg ^ h2_reg ^ phi_reg ^ {{(WORD_W-AW){1'b0}}, cnt_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            idx_reg     <= LAST_IDX;
            carry_reg   <= SEED_CARRY;
            seeding_reg <= 1'b0;
            phi_reg     <= PHI_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            carry_reg   <= carry_next;
            seeding_reg <= seeding_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                phi_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers: no reset
    always_ff @(posedge aclk) begin
        h1_reg        <= h1_next;
        h2_reg        <= h2_next;
        h3_reg        <= h3_next;
        res_value_reg <= res_value_next;
        res_done_reg  <= res_done_next;
        m_value_reg   <= m_value_next;
        m_done_reg    <= m_done_next;
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        carry_next     = carry_reg;
        seeding_next   = seeding_reg;
        h1_next        = h1_reg;
        h2_next        = h2_reg;
        h3_next        = h3_reg;
        res_value_next = res_value_reg;
        res_done_next  = res_done_reg;
        m_valid_next   = m_valid_reg & ~m_ready;
        m_value_next   = m_value_reg;
        m_done_next    = m_done_reg;
        s_ready        = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = mwc_res.entry;
        ram_raddr      = idx_reg + AW'(1);

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_op == OP_SEED) begin
                        h1_next    = s_seed_value;
                        cnt_next   = '0;
                        state_next = ST_FILL;
                    end else begin
                        seeding_next = 1'b0;
                        state_next   = ST_RD;
                    end
                end
            end
            ST_FILL: begin
                // write one word a cycle, shift the history
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = fill_val;
                h1_next   = fill_val;
                h2_next   = h1_reg;
                h3_next   = h2_reg;
                if (cnt_reg == LAST_IDX) begin
                    carry_next   = SEED_CARRY;
                    idx_next     = LAST_IDX;
                    cnt_next     = '0;
                    seeding_next = 1'b1;
                    state_next   = ST_RD;
                end else begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            ST_RD: begin
                // advance the index and fetch the lag word
                idx_next   = idx_reg + AW'(1);
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_ADD;
            end
            ST_ADD: begin
                ram_we     = 1'b1;
                carry_next = mwc_res.carry;
                if (seeding_reg) begin
                    if (cnt_reg == LAST_IDX) begin
                        res_value_next = '0;
                        res_done_next  = 1'b1;
                        state_next     = ST_OUT;
                    end else begin
                        cnt_next   = cnt_reg + AW'(1);
                        state_next = ST_RD;
                    end
                end else begin
                    res_value_next = mwc_res.entry;
                    res_done_next  = 1'b0;
                    state_next     = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_value_next = res_value_reg;
                    m_done_next  = res_done_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_random_value = m_value_reg;
    assign m_seed_done    = m_done_reg;

endmodule

// File: rtl/core/cmwc_checker.sv
module cmwc_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [cmwc_pkg::WORD_W-1:0] m_random_value,
    input  logic                        m_seed_done
);
    import cmwc_pkg::*;

    // after reset: idle and nothing pending
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("block not idle after reset");

    // one item at a time: busy right after an acceptance
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is in progress");

    // a seed acknowledgement carries a zero word
    a_ack_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_seed_done |-> m_random_value == '0)
        else $error("seed acknowledgement with non-zero value");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_random_value) && $stable(m_seed_done))
        else $error("stalled result changed");

endmodule

bind cmwc_lag_table_random_generator cmwc_checker u_checker (.*);
